### rtl/tme_pkg.sv
// Shared types and constants of the tape machine executor.
package tme_pkg;

	localparam int unsigned AMT_W  = 12;
	localparam int unsigned CELL_W = 8;
	localparam int unsigned CNT_W  = 11;
	localparam int unsigned OP_W   = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 3'd0,
		OP_MOVE  = 3'd1,
		OP_READ  = 3'd2,
		OP_PRINT = 3'd3,
		OP_JZ    = 3'd4,
		OP_JNZ   = 3'd5
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic signed [AMT_W-1:0] amount;
		logic [CELL_W-1:0]       in_byte;
	} item_t;

	typedef struct packed {
		logic              print_valid;
		logic [CELL_W-1:0] print_char;
		logic [CNT_W-1:0]  print_count;
		logic              jump_taken;
		logic              mem_error;
	} rsp_t;

	// Write-back request from the execute stage to the tape memory.
	typedef struct packed {
		logic              en;
		logic [CELL_W-1:0] data;
	} cell_wr_t;

endpackage

### rtl/tme_tape.sv
// Tape memory: synchronous RAM with post-reset clearing sweep and write-to-read forwarding.
module tme_tape
	import tme_pkg::*;
#(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [CELL_W-1:0] wr_data,
	output logic [CELL_W-1:0] rd_data,
	output logic              clearing
);

	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic [CELL_W-1:0] mem [DEPTH];
	logic [CELL_W-1:0] rd_q;
	logic [CELL_W-1:0] fwd_data_q;
	logic              fwd_q;
	logic [AW-1:0]     clr_addr_q;
	logic              clearing_q;

	logic              we;
	logic [AW-1:0]     wa;
	logic [CELL_W-1:0] wd;

	// Sweep zeros through every entry after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clearing_q) begin
			we = 1'b1;
			wa = clr_addr_q;
			wd = '0;
		end else begin
			we = wr_en;
			wa = wr_addr;
			wd = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// A write on the same edge as the read returns old data; capture the new value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= wr_data;
		end
	end

	assign rd_data  = fwd_q ? fwd_data_q : rd_q;
	assign clearing = clearing_q;

endmodule

### rtl/tme_exec.sv
// Execute stage: cell update, print and jump decisions for one request.
module tme_exec
	import tme_pkg::*;
(
	input  item_t             item,
	input  logic [CELL_W-1:0] cur_cell,
	input  logic              ignore,
	input  logic              err_after,
	output cell_wr_t          wr,
	output rsp_t              rsp
);

	logic amt_pos;
	logic cell_nz;

	assign amt_pos = !item.amount[AMT_W-1] && (|item.amount[AMT_W-2:0]);
	assign cell_nz = |cur_cell;

	always_comb begin
		wr  = '0;
		rsp = '0;
		rsp.mem_error = err_after;
		if (!ignore) begin
			unique case (op_t'(item.op))
				OP_ADD: begin
					wr.en   = 1'b1;
					wr.data = cur_cell + item.amount[CELL_W-1:0];
				end
				OP_READ: begin
					wr.en   = amt_pos;
					wr.data = item.in_byte;
				end
				OP_PRINT: begin
					if (amt_pos && cell_nz) begin
						rsp.print_valid = 1'b1;
						rsp.print_char  = cur_cell;
						rsp.print_count = item.amount[CNT_W-1:0];
					end
				end
				OP_JZ: begin
					rsp.jump_taken = !cell_nz;
				end
				OP_JNZ: begin
					rsp.jump_taken = cell_nz;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/tape_machine_executor_top.sv
// Top level of the tape machine executor: pointer, error flag, pipeline and output register.
//
// Executes one run-length compressed tape-machine request per cycle while req_stall is low,
// against a byte tape of TAPE_DEPTH cells held in a single-port-write, registered-read RAM. A
// request accepted at an edge reads its cell at that edge, is executed in the execute stage,
// and is written back as its result moves into the output register and onto the response
// channel; requests can follow each other every cycle when not stalled, since a cell written
// back is forwarded to a read issued on the same edge. Moves and the bounds check update the
// pointer at acceptance, so the next request already reads the new cell. An output register
// parts the response side: while it holds an untaken result the block still takes one more
// request; once clearing is over it stalls only when both the execute stage and the output
// register are full. After reset the tape is cleared one cell per cycle, so req_stall stays
// high until every cell is cleared. A move off the tape sets a sticky mem_error; every later
// request then returns a result with only mem_error set and changes nothing, until reset.
module tape_machine_executor_top
	import tme_pkg::*;
#(
	parameter int unsigned TAPE_DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [OP_W-1:0]          req_type,
	input  logic signed [AMT_W-1:0]  amount,
	input  logic [CELL_W-1:0]        in_byte,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic                     print_valid,
	output logic [CELL_W-1:0]        print_char,
	output logic [CNT_W-1:0]         print_count,
	output logic                     jump_taken,
	output logic                     mem_error
);

	localparam int unsigned PTR_W = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
	localparam int unsigned SUM_W = ((PTR_W > AMT_W) ? PTR_W : AMT_W) + 2;
	localparam logic signed [SUM_W-1:0] DEPTH_S = SUM_W'(TAPE_DEPTH);

	// Architectural state updated at acceptance.
	logic [PTR_W-1:0] ptr_q;
	logic             err_q;

	// Execute stage.
	logic             valid_s1;
	item_t            item_s1;
	logic [PTR_W-1:0] addr_s1;
	logic             ign_s1;
	logic             err_s1;

	// Output register.
	logic             out_valid_q;
	rsp_t             rsp_q;

	logic              clearing;
	logic              accept;
	logic              adv_s1;
	logic [CELL_W-1:0] cur_cell;
	cell_wr_t          wr;
	rsp_t              rsp_c;
	item_t             item_in;

	logic signed [SUM_W-1:0] next_ptr;
	logic                    off_tape;
	logic [PTR_W-1:0]        ptr_d;
	logic                    err_d;

	assign item_in = '{op: req_type, amount: amount, in_byte: in_byte};

	// Advance the execute stage when the output register is free or being taken.
	assign adv_s1    = valid_s1 && (!out_valid_q || !rsp_stall);
	assign req_stall = clearing || (valid_s1 && !adv_s1);
	assign accept    = req_valid && !req_stall;

	// Pointer step and bounds check.
	assign next_ptr = $signed({{(SUM_W-PTR_W){1'b0}}, ptr_q})
		+ $signed({{(SUM_W-AMT_W){amount[AMT_W-1]}}, amount});
	assign off_tape = next_ptr[SUM_W-1] || (next_ptr >= DEPTH_S);

	always_comb begin
		ptr_d = ptr_q;
		err_d = err_q;
		if (!err_q && (req_type == OP_MOVE)) begin
			if (off_tape) begin
				err_d = 1'b1;
			end else begin
				ptr_d = next_ptr[PTR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			err_q <= 1'b0;
		end else if (accept) begin
			ptr_q <= ptr_d;
			err_q <= err_d;
		end
	end

	// Load the execute stage on acceptance; drop it once its result moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
			addr_s1 <= ptr_q;
			ign_s1  <= err_q;
			err_s1  <= err_d;
		end
	end

	tme_tape #(
		.DEPTH(TAPE_DEPTH),
		.AW   (PTR_W)
	) u_tape (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (ptr_q),
		.wr_en   (adv_s1 && wr.en),
		.wr_addr (addr_s1),
		.wr_data (wr.data),
		.rd_data (cur_cell),
		.clearing(clearing)
	);

	tme_exec u_exec (
		.item     (item_s1),
		.cur_cell (cur_cell),
		.ignore   (ign_s1),
		.err_after(err_s1),
		.wr       (wr),
		.rsp      (rsp_c)
	);

	// Hold the result until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q <= rsp_c;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign print_valid = rsp_q.print_valid;
	assign print_char  = rsp_q.print_char;
	assign print_count = rsp_q.print_count;
	assign jump_taken  = rsp_q.jump_taken;
	assign mem_error   = rsp_q.mem_error;

endmodule

### rtl/tme_checker.sv
// Port-level checker for the tape machine executor, bound to the top level.
module tme_checker
	import tme_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input logic              print_valid,
	input logic [CELL_W-1:0] print_char,
	input logic [CNT_W-1:0]  print_count,
	input logic              jump_taken,
	input logic              mem_error
);

	logic seen_err_q;

	// Remember a delivered error; it must stay for every later result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_err_q <= 1'b0;
		end else if (rsp_valid && !rsp_stall && mem_error) begin
			seen_err_q <= 1'b1;
		end
	end

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && seen_err_q |-> mem_error)
		else $error("mem_error cleared after being reported");

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && seen_err_q |-> !print_valid && !jump_taken)
		else $error("request acted on while the error was set");

	a_print_nz: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && print_valid |-> (print_char != '0) && (print_count != '0))
		else $error("print emitted a zero cell or zero count");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(print_valid && jump_taken))
		else $error("print and jump reported by one request");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(print_char) && $stable(mem_error))
		else $error("stalled response changed");

endmodule

bind tape_machine_executor_top tme_checker u_tme_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.print_valid(print_valid),
	.print_char (print_char),
	.print_count(print_count),
	.jump_taken (jump_taken),
	.mem_error  (mem_error)
);
